>>> hw/rtl/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg: shared constants, types and helpers
// sizes, opcodes, register map and the word formats that travel the chain
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int MAX_DIM = 8;
  localparam int ELEM_W  = 16;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int SUM_W   = PROD_W + IDX_W;
  localparam int REG_W   = 4;
  localparam int RST_DIM = 8;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int RIDX_W  = ADDR_W - 2;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  localparam logic [RIDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [RIDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [RIDX_W-1:0] REG_COLS_B    = 2'd2;

  // partial-sum word handed from cell to cell
  typedef struct packed {
    logic                    valid;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
    logic signed [SUM_W-1:0] psum;
  } tok_t;

  // store write broadcast to all cells
  typedef struct packed {
    logic                     a_we;
    logic                     b_we;
    logic [IDX_W-1:0]         dest;
    logic [IDX_W-1:0]         addr;
    logic signed [ELEM_W-1:0] data;
  } wr_t;

  // zero reads as one, anything above the array size clips to it
  function automatic logic [CNT_W-1:0] dim_sat(input logic [REG_W-1:0] r);
    logic [CNT_W-1:0] d;
    if (r == '0) begin
      d = CNT_W'(1);
    end else if (int'(r) > MAX_DIM) begin
      d = CNT_W'(MAX_DIM);
    end else begin
      d = CNT_W'(r);
    end
    return d;
  endfunction

endpackage

>>> hw/rtl/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply: C = A * B over local Q4.12 stores, exact Q11.24 results
// load words go into a chain of MAX_DIM cells, a compute word streams C out
// ----------------------------------------------------------------------------
// loads: one word per cycle while in_ready is high, no result
// compute: the first element of C comes out through the sequencer, the chain of cells
//   and the output register, then one per cycle unless out_ready stalls
// in_ready stays low until the last of the rows_a * cols_b elements is taken, so
//   the next word goes in only after that
// reset: sync, clears control, sets the dimension registers to 8; stores undefined
module matrix_multiply (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       op,
  input  logic [mm_pkg::IDX_W-1:0]         row,
  input  logic [mm_pkg::IDX_W-1:0]         col,
  input  logic signed [mm_pkg::ELEM_W-1:0] value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mm_pkg::IDX_W-1:0]         out_row,
  output logic [mm_pkg::IDX_W-1:0]         out_col,
  output logic signed [mm_pkg::SUM_W-1:0]  sum,
  output logic                             last,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mm_pkg::ADDR_W-1:0]        paddr,
  input  logic [mm_pkg::DATA_W-1:0]        pwdata,
  output logic [mm_pkg::DATA_W-1:0]        prdata,
  output logic                             pready
);

  logic [mm_pkg::REG_W-1:0]  rows_a;
  logic [mm_pkg::REG_W-1:0]  inner_dim;
  logic [mm_pkg::REG_W-1:0]  cols_b;
  logic [mm_pkg::RIDX_W-1:0] reg_idx;
  logic                      cfg_we;

  logic                      busy;
  logic                      in_acc;
  logic                      in_range;
  logic                      start;
  logic                      en;
  mm_pkg::wr_t               wr;
  mm_pkg::tok_t              tok [mm_pkg::MAX_DIM + 1];

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[mm_pkg::ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= mm_pkg::REG_W'(mm_pkg::RST_DIM);
      inner_dim <= mm_pkg::REG_W'(mm_pkg::RST_DIM);
      cols_b    <= mm_pkg::REG_W'(mm_pkg::RST_DIM);
    end else if (cfg_we) begin
      unique case (reg_idx)
        mm_pkg::REG_ROWS_A:    rows_a    <= pwdata[mm_pkg::REG_W-1:0];
        mm_pkg::REG_INNER_DIM: inner_dim <= pwdata[mm_pkg::REG_W-1:0];
        mm_pkg::REG_COLS_B:    cols_b    <= pwdata[mm_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mm_pkg::REG_ROWS_A:    prdata = mm_pkg::DATA_W'(rows_a);
      mm_pkg::REG_INNER_DIM: prdata = mm_pkg::DATA_W'(inner_dim);
      mm_pkg::REG_COLS_B:    prdata = mm_pkg::DATA_W'(cols_b);
      default:               prdata = '0;
    endcase
  end

  // input side
  assign in_ready = !busy;
  assign in_acc   = in_valid && in_ready;
  assign in_range = int'(row) < mm_pkg::MAX_DIM && int'(col) < mm_pkg::MAX_DIM;
  assign start    = in_acc && op == mm_pkg::OP_COMPUTE;

  // A[r][c] lives in cell c at slot r, B[r][c] in cell r at slot c
  always_comb begin
    wr.a_we = in_acc && in_range && op == mm_pkg::OP_LOAD_A;
    wr.b_we = in_acc && in_range && op == mm_pkg::OP_LOAD_B;
    wr.dest = (op == mm_pkg::OP_LOAD_A) ? col : row;
    wr.addr = (op == mm_pkg::OP_LOAD_A) ? row : col;
    wr.data = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (out_valid && out_ready && last) begin
      busy <= 1'b0;
    end
  end

  // whole chain advances together whenever the output word can move
  assign en = !out_valid || out_ready;

  mm_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .start (start),
    .m     (mm_pkg::dim_sat(rows_a)),
    .n     (mm_pkg::dim_sat(cols_b)),
    .tok   (tok[0])
  );

  for (genvar g = 0; g < mm_pkg::MAX_DIM; g++) begin : g_cell
    mm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .idx     (mm_pkg::IDX_W'(g)),
      .kd      (mm_pkg::dim_sat(inner_dim)),
      .wr      (wr),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tok[mm_pkg::MAX_DIM].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_row <= tok[mm_pkg::MAX_DIM].row;
      out_col <= tok[mm_pkg::MAX_DIM].col;
      sum     <= tok[mm_pkg::MAX_DIM].psum;
      last    <= tok[mm_pkg::MAX_DIM].last;
    end
  end

endmodule

>>> hw/rtl/mm_cell.sv
// ----------------------------------------------------------------------------
// mm_cell: one multiply-accumulate cell of the chain
// holds column k of A and row k of B, adds a[i][k]*b[k][j] to the passing word
// ----------------------------------------------------------------------------
module mm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [mm_pkg::IDX_W-1:0]   idx,
  input  logic [mm_pkg::CNT_W-1:0]   kd,
  input  mm_pkg::wr_t                wr,
  input  mm_pkg::tok_t               tok_in,
  output mm_pkg::tok_t               tok_out
);

  logic signed [mm_pkg::ELEM_W-1:0] a_col [mm_pkg::MAX_DIM];
  logic signed [mm_pkg::ELEM_W-1:0] b_row [mm_pkg::MAX_DIM];
  logic signed [mm_pkg::PROD_W-1:0] prod;
  logic signed [mm_pkg::SUM_W-1:0]  prod_ext;
  logic                             active;
  mm_pkg::tok_t                     tok_next;

  always_ff @(posedge clk) begin
    if (wr.a_we && wr.dest == idx) begin
      a_col[wr.addr] <= wr.data;
    end
    if (wr.b_we && wr.dest == idx) begin
      b_row[wr.addr] <= wr.data;
    end
  end

  assign prod     = a_col[tok_in.row] * b_row[tok_in.col];
  assign prod_ext = {{(mm_pkg::SUM_W - mm_pkg::PROD_W){prod[mm_pkg::PROD_W-1]}}, prod};
  // cells past the inner dimension just pass the word along
  assign active   = mm_pkg::CNT_W'(idx) < kd;

  always_comb begin
    tok_next = tok_in;
    if (active) begin
      tok_next.psum = tok_in.psum + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

endmodule

>>> hw/rtl/mm_seq.sv
// ----------------------------------------------------------------------------
// mm_seq: product element sequencer
// walks the elements of C in row-major order and, while en is high, feeds one word per cycle
// ----------------------------------------------------------------------------
module mm_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     start,
  input  logic [mm_pkg::CNT_W-1:0] m,
  input  logic [mm_pkg::CNT_W-1:0] n,
  output mm_pkg::tok_t             tok
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t                   state;
  logic [mm_pkg::IDX_W-1:0] i;
  logic [mm_pkg::IDX_W-1:0] j;
  logic                     last_i;
  logic                     last_j;

  assign last_i = mm_pkg::CNT_W'(i) == m - 1'b1;
  assign last_j = mm_pkg::CNT_W'(j) == n - 1'b1;

  always_comb begin
    tok       = '0;
    tok.valid = state == RUN;
    tok.row   = i;
    tok.col   = j;
    tok.last  = last_i && last_j;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      i     <= '0;
      j     <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            state <= RUN;
            i     <= '0;
            j     <= '0;
          end
        end
        RUN: begin
          if (en) begin
            if (last_j) begin
              j <= '0;
              if (last_i) begin
                state <= IDLE;
              end else begin
                i <= i + 1'b1;
              end
            end else begin
              j <= j + 1'b1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/mm_checker.sv
// ----------------------------------------------------------------------------
// mm_checker: port-level checks for matrix_multiply
// output handshake and the busy window around a compute
// ----------------------------------------------------------------------------
module mm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [mm_pkg::SUM_W-1:0] sum,
  input logic                            last
);

  // a stalled result word stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sum) && $stable(last))
    else $error("stalled output word changed");

  // no result words while idle
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("output word while idle");

  // taking the final element frees the input
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready)
    else $error("input not freed after last element");

  // a compute keeps the input closed until its last element goes out
  assert property (@(posedge clk) disable iff (rst)
    !in_ready && !(out_valid && out_ready && last) |=> !in_ready)
    else $error("input reopened before last element");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sum       (sum),
  .last      (last)
);
